[design/bbc_pkg.sv]
// bbc_pkg: codes, sizes and cell control/status types of the block buffer cache tag controller
// depends on nothing; used by bbc_cell and block_buffer_cache_tags
`timescale 1ns / 1ps
`default_nettype none

package bbc_pkg;

    localparam int SLOTS_DEF      = 16;
    localparam int BLOCK_BITS_DEF = 16;

    localparam int SLOT_W  = 4;
    localparam int MODE_W  = 2;
    localparam int OP_W    = 2;
    localparam int DBLK_W  = 16;

    localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd2;

    localparam logic [OP_W-1:0] OP_NONE  = 2'd0;
    localparam logic [OP_W-1:0] OP_FETCH = 2'd1;
    localparam logic [OP_W-1:0] OP_WB    = 2'd2;

    // broadcast to every cell in the chain
    typedef struct packed {
        logic set_dirty_hit;  // matching cell becomes dirty
        logic alloc;          // lowest empty cell takes the block
        logic evict0;         // first cell takes the block (cache full)
        logic fill_dirty;     // dirty value of the newly filled cell
        logic tok_step;       // flush token moves one cell down
    } cell_ctl_t;

    typedef struct packed {
        logic match;
        logic alloc_sel;
        logic dirty;
        logic tok;
        logic wb_req;
    } cell_stat_t;

endpackage

`default_nettype wire

[design/block_buffer_cache_tags.sv]
// block_buffer_cache_tags: tag and dirty-bit controller of a fully associative write-back cache
// depends on bbc_pkg and bbc_cell (one cell per slot, chained)
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  request | s_valid s_ready s_mode s_block_number         | in
//  result  | m_valid m_ready m_slot m_hit m_disk_op        | out
//          | m_disk_block m_last                           |
//
// read/write hit, or miss into an empty or clean slot: accepted once the previous result is
// taken, result registered in the cycle after acceptance; all tags compared in the accept cycle
// miss that evicts a dirty slot 0: a write-back transaction, then the request's result
// flush: the token walks the cell chain one slot per cycle while no write-back waits on
// m_ready, then a done transaction closes the flush; a stalled result holds the controller
// in place
// synchronous active-low reset clears valid, dirty and the flush token; tags need no reset
`timescale 1ns / 1ps
`default_nettype none

module block_buffer_cache_tags
    import bbc_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [MODE_W-1:0] s_mode,
    input  wire logic [DBLK_W-1:0] s_block_number,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [SLOT_W-1:0]      m_slot,
    output logic                   m_hit,
    output logic [OP_W-1:0]        m_disk_op,
    output logic [DBLK_W-1:0]      m_disk_block,
    output logic                   m_last
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FINAL = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] state_reg, state_next;

    logic              m_valid_reg, m_valid_next;
    logic [SLOT_W-1:0] m_slot_reg, m_slot_next;
    logic              m_hit_reg, m_hit_next;
    logic [OP_W-1:0]   m_disk_op_reg, m_disk_op_next;
    logic [DBLK_W-1:0] m_disk_block_reg, m_disk_block_next;
    logic              m_last_reg, m_last_next;

    logic              req_read_reg, req_read_next;
    logic [DBLK_W-1:0] req_blk_reg, req_blk_next;

    cell_ctl_t             ctl;
    cell_stat_t            stat [SLOTS];
    logic [BLOCK_BITS-1:0] cell_tag [SLOTS];
    logic [SLOTS:0]        free_chain;
    logic [SLOTS:0]        tok_chain;
    logic                  tok_start;

    logic [BLOCK_BITS-1:0] blk_in;
    logic [DBLK_W-1:0]     blk16;
    logic [BLOCK_BITS-1:0] tok_tag;
    logic [DBLK_W-1:0]     tok_tag16;
    logic [DBLK_W-1:0]     tag0_16;
    logic [SLOT_W-1:0]     hit_slot, alloc_slot, tok_slot;
    logic                  any_match, any_wb, all_full;
    logic                  out_free, accept, is_write, advance;

    // block number width conversions
    for (genvar b = 0; b < BLOCK_BITS; b++) begin : g_blk_in
        if (b < DBLK_W) begin : g_bit
            assign blk_in[b] = s_block_number[b];
        end else begin : g_zero
            assign blk_in[b] = 1'b0;
        end
    end

    for (genvar b = 0; b < DBLK_W; b++) begin : g_blk16
        if (b < BLOCK_BITS) begin : g_bit
            assign blk16[b]     = blk_in[b];
            assign tok_tag16[b] = tok_tag[b];
            assign tag0_16[b]   = cell_tag[0][b];
        end else begin : g_zero
            assign blk16[b]     = 1'b0;
            assign tok_tag16[b] = 1'b0;
            assign tag0_16[b]   = 1'b0;
        end
    end

    assign free_chain[0] = 1'b0;
    assign tok_chain[0]  = tok_start;

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        bbc_cell #(
            .BLOCK_BITS (BLOCK_BITS),
            .IS_FIRST   (i == 0)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .blk_in   (blk_in),
            .free_in  (free_chain[i]),
            .tok_in   (tok_chain[i]),
            .free_out (free_chain[i+1]),
            .tag_out  (cell_tag[i]),
            .stat     (stat[i])
        );
        assign tok_chain[i+1] = stat[i].tok;
    end

    assign all_full = !free_chain[SLOTS];

    // at most one cell matches, allocates or holds the token, so or-ing is enough
    always_comb begin
        hit_slot   = '0;
        alloc_slot = '0;
        tok_slot   = '0;
        tok_tag    = '0;
        any_match  = 1'b0;
        any_wb     = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (stat[i].match) begin
                hit_slot = hit_slot | SLOT_W'(i);
            end
            if (stat[i].alloc_sel) begin
                alloc_slot = alloc_slot | SLOT_W'(i);
            end
            if (stat[i].tok) begin
                tok_slot = tok_slot | SLOT_W'(i);
                tok_tag  = tok_tag | cell_tag[i];
            end
            any_match = any_match | stat[i].match;
            any_wb    = any_wb | stat[i].wb_req;
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign is_write = (s_mode == MODE_WRITE);
    assign advance  = !any_wb || out_free;

    always_comb begin
        state_next        = state_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_slot_next       = m_slot_reg;
        m_hit_next        = m_hit_reg;
        m_disk_op_next    = m_disk_op_reg;
        m_disk_block_next = m_disk_block_reg;
        m_last_next       = m_last_reg;
        req_read_next     = req_read_reg;
        req_blk_next      = req_blk_reg;
        ctl               = '0;
        tok_start         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_mode)
                        MODE_READ, MODE_WRITE: begin
                            m_valid_next = 1'b1;
                            m_last_next  = 1'b1;
                            if (any_match) begin
                                ctl.set_dirty_hit = is_write;
                                m_slot_next       = hit_slot;
                                m_hit_next        = 1'b1;
                                m_disk_op_next    = OP_NONE;
                                m_disk_block_next = '0;
                            end else begin
                                ctl.fill_dirty    = is_write;
                                ctl.alloc         = !all_full;
                                ctl.evict0        = all_full;
                                m_slot_next       = all_full ? '0 : alloc_slot;
                                m_hit_next        = 1'b0;
                                m_disk_op_next    = is_write ? OP_NONE : OP_FETCH;
                                m_disk_block_next = is_write ? '0 : blk16;
                                if (all_full && stat[0].dirty) begin
                                    // write back the evicted slot first
                                    m_disk_op_next    = OP_WB;
                                    m_disk_block_next = tag0_16;
                                    m_last_next       = 1'b0;
                                    req_read_next     = !is_write;
                                    req_blk_next      = blk16;
                                    state_next        = ST_FINAL;
                                end
                            end
                        end
                        MODE_FLUSH: begin
                            tok_start    = 1'b1;
                            ctl.tok_step = 1'b1;
                            state_next   = ST_FLUSH;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_slot_next       = '0;
                    m_hit_next        = 1'b0;
                    m_disk_op_next    = req_read_reg ? OP_FETCH : OP_NONE;
                    m_disk_block_next = req_read_reg ? req_blk_reg : '0;
                    m_last_next       = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (any_wb && out_free) begin
                    m_valid_next      = 1'b1;
                    m_slot_next       = tok_slot;
                    m_hit_next        = 1'b0;
                    m_disk_op_next    = OP_WB;
                    m_disk_block_next = tok_tag16;
                    m_last_next       = 1'b0;
                end
                ctl.tok_step = advance;
                if (advance && tok_chain[SLOTS]) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_slot_next       = '0;
                    m_hit_next        = 1'b0;
                    m_disk_op_next    = OP_NONE;
                    m_disk_block_next = '0;
                    m_last_next       = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_slot_reg       <= m_slot_next;
        m_hit_reg        <= m_hit_next;
        m_disk_op_reg    <= m_disk_op_next;
        m_disk_block_reg <= m_disk_block_next;
        m_last_reg       <= m_last_next;
        req_read_reg     <= req_read_next;
        req_blk_reg      <= req_blk_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_slot       = m_slot_reg;
    assign m_hit        = m_hit_reg;
    assign m_disk_op    = m_disk_op_reg;
    assign m_disk_block = m_disk_block_reg;
    assign m_last       = m_last_reg;

    // no new transaction while a request is still being worked off
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("request accepted while controller busy");

    // the flush token sits in at most one cell
    a_tok_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok_chain[SLOTS:1]))
        else $error("flush token duplicated");

    // a flush always closes with a done transaction
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=>
            (m_valid && m_last && m_disk_op == OP_NONE && state_reg == ST_IDLE))
        else $error("flush did not end with done");

    // an eviction write-back is always followed by the request's own result
    a_wb_then_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINAL) |-> (m_valid && m_disk_op == OP_WB && !m_last))
        else $error("pending eviction without a write-back in flight");

endmodule

`default_nettype wire

[design/bbc_cell.sv]
// bbc_cell: one cache slot: tag, valid and dirty bits, free-slot chain and flush token stage
// depends on bbc_pkg
`timescale 1ns / 1ps
`default_nettype none

module bbc_cell
    import bbc_pkg::*;
#(
    parameter int BLOCK_BITS = BLOCK_BITS_DEF,
    parameter bit IS_FIRST   = 1'b0
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cell_ctl_t             ctl,
    input  wire logic [BLOCK_BITS-1:0] blk_in,
    input  wire logic                  free_in,
    input  wire logic                  tok_in,
    output logic                       free_out,
    output logic [BLOCK_BITS-1:0]      tag_out,
    output cell_stat_t                 stat
);

    logic [BLOCK_BITS-1:0] tag_reg;
    logic                  valid_reg, valid_next;
    logic                  dirty_reg, dirty_next;
    logic                  tok_reg, tok_next;
    logic                  match;
    logic                  alloc_sel;
    logic                  fill;

    assign match     = valid_reg && (tag_reg == blk_in);
    assign alloc_sel = !valid_reg && !free_in;
    assign free_out  = free_in || !valid_reg;
    assign fill      = (ctl.alloc && alloc_sel) || (ctl.evict0 && IS_FIRST);

    always_comb begin
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        tok_next   = ctl.tok_step ? tok_in : tok_reg;
        if (fill) begin
            valid_next = 1'b1;
            dirty_next = ctl.fill_dirty;
        end else if (ctl.set_dirty_hit && match) begin
            dirty_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            dirty_reg <= 1'b0;
            tok_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fill) begin
            tag_reg <= blk_in;
        end
    end

    assign tag_out        = tag_reg;
    assign stat.match     = match;
    assign stat.alloc_sel = alloc_sel;
    assign stat.dirty     = valid_reg && dirty_reg;
    assign stat.tok       = tok_reg;
    assign stat.wb_req    = tok_reg && valid_reg && dirty_reg;

endmodule

`default_nettype wire
